// ----- sv/mvm_pkg.sv -----
package mvm_pkg;

  // Array size and element format.
  localparam int MAX_N    = 16;
  localparam int IDX_W    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int MADDR_W  = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int SUM_W    = 40;
  localparam int SIZE_W   = 5;
  localparam int SIZE_RST = 16;

  // Field widths of the words on the two channels.
  localparam int KIND_W    = 2;
  localparam int ROWF_W    = 4;
  localparam int COLF_W    = 4;
  localparam int VALUE_W   = 16;
  localparam int OUT_ROW_W = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_MAT = 2'd0,
    KIND_LOAD_VEC = 2'd1,
    KIND_COMPUTE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    kind_t                      kind;
    logic [ROWF_W-1:0]          row_index;
    logic [COLF_W-1:0]          col_index;
    logic signed [VALUE_W-1:0]  value;
  } cmd_word_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0]       out_row;
    logic signed [SUM_W-1:0]    dot_sum;
    logic                       last;
  } res_word_t;

  // Control that travels with each element pair down the pipeline.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic             first_col;
    logic             last_col;
    logic             last_row;
  } tag_t;

endpackage

// ----- sv/mvm_ram.sv -----
module mvm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while re is low, so a frozen pipeline keeps its operand.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/mvm_mac.sv -----
module mvm_mac
  import mvm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  tag_t              tag,
  input  logic [ELEM_W-1:0] mat_q,
  input  logic [ELEM_W-1:0] vec_q,
  output logic              busy,
  output logic              fire,
  output res_word_t         word
);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod;
  tag_t                     tag2;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W:0]    base;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_sat;

  // Stage one: the product, registered before the add.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= $signed(mat_q) * $signed(vec_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
    end else if (adv) begin
      tag2 <= tag;
    end
  end

  // Stage two: accumulate, restarting from zero at the first column of a row.
  always_comb begin
    base     = tag2.first_col ? '0 : (SUM_W+1)'(acc);
    sum_wide = base + (SUM_W+1)'(prod);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tag2.valid) begin
      acc <= sum_sat;
    end
  end

  assign busy         = tag2.valid;
  assign fire         = adv && tag2.valid && tag2.last_col;
  assign word.out_row = OUT_ROW_W'(tag2.row);
  assign word.dot_sum = sum_sat;
  assign word.last    = tag2.last_row;

endmodule

// ----- sv/matrix_vector_multiply.sv -----
// Dense matrix times vector in signed fixed point.
//
// The cmd channel carries one word per item: a matrix element load, a
// vector element load, or a compute request. Loads write the element
// into its store and give no result; one is taken every cycle when idle.
// A compute walks the top-left n by n part of the matrix, with n taken
// from size_in_use (0 acts as 1, above MAX_N acts as MAX_N), and sends
// one res word per row in row order, the final one marked with last.
// Each dot_sum is the exact Q24.16 sum of the row's Q8.8 products.
//
// The matrix and vector stores are synchronous memories read at one
// column per cycle while the pipeline is not frozen. While a compute is
// in flight cmd_stall is high. A res word waits in an output register;
// while that word is stalled the whole read and multiply pipeline
// freezes, and the next command word can be taken as soon as the
// pipeline has drained, even with a result pending.
// Reset clears the control state and sets size_in_use to 16; the stores
// hold nothing defined until they are written.
module matrix_vector_multiply
  import mvm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_word_t         cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output res_word_t         res
);

  state_t            state, state_next;
  logic [SIZE_W-1:0] size_in_use;
  logic [IDX_W-1:0]  ci, ci_next;
  logic [IDX_W-1:0]  cj, cj_next;
  logic [IDX_W-1:0]  n_last, n_last_next;
  tag_t              tag1, tag1_next;

  logic              adv;
  logic              cmd_accept;
  logic              start;
  logic              issue;
  logic              col_end;
  logic              row_end;
  logic              mat_we;
  logic              vec_we;
  logic [MADDR_W-1:0] mat_waddr;
  logic [MADDR_W-1:0] mat_raddr;
  logic [ELEM_W-1:0] mat_q;
  logic [ELEM_W-1:0] vec_q;
  logic              mac_busy;
  logic              mac_fire;
  res_word_t         mac_word;

  // The pipeline moves unless a finished word is held by the receiver.
  assign adv        = !(res_valid && res_stall);
  assign cmd_stall  = (state != ST_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign start      = cmd_accept && (cmd.kind == KIND_COMPUTE);
  assign issue      = (state == ST_RUN) && adv;
  assign col_end    = (cj == n_last);
  assign row_end    = (ci == n_last);

  // Loads with an index beyond the array are dropped.
  assign mat_we = cmd_accept && (cmd.kind == KIND_LOAD_MAT)
                  && (32'(cmd.row_index) < 32'(MAX_N))
                  && (32'(cmd.col_index) < 32'(MAX_N));
  assign vec_we = cmd_accept && (cmd.kind == KIND_LOAD_VEC)
                  && (32'(cmd.col_index) < 32'(MAX_N));

  assign mat_waddr = MADDR_W'(MADDR_W'(cmd.row_index) * MADDR_W'(MAX_N)
                              + MADDR_W'(cmd.col_index));
  assign mat_raddr = MADDR_W'(MADDR_W'(ci) * MADDR_W'(MAX_N) + MADDR_W'(cj));

  mvm_ram #(
    .DEPTH (MAX_N * MAX_N),
    .WIDTH (ELEM_W)
  ) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (cmd.value[ELEM_W-1:0]),
    .re    (issue),
    .raddr (mat_raddr),
    .rdata (mat_q)
  );

  mvm_ram #(
    .DEPTH (MAX_N),
    .WIDTH (ELEM_W)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (IDX_W'(cmd.col_index)),
    .wdata (cmd.value[ELEM_W-1:0]),
    .re    (issue),
    .raddr (cj),
    .rdata (vec_q)
  );

  mvm_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .tag   (tag1),
    .mat_q (mat_q),
    .vec_q (vec_q),
    .busy  (mac_busy),
    .fire  (mac_fire),
    .word  (mac_word)
  );

  // Next state. Loads never start while reads are in flight, since the
  // machine only returns to idle once the pipeline is empty.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && col_end && row_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!tag1.valid && !mac_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Walk counters and the tag for the element pair being read.
  always_comb begin
    ci_next     = ci;
    cj_next     = cj;
    n_last_next = n_last;
    tag1_next   = tag1;
    if (start) begin
      ci_next = '0;
      cj_next = '0;
      if (size_in_use == '0) begin
        n_last_next = '0;
      end else if (32'(size_in_use) > 32'(MAX_N)) begin
        n_last_next = IDX_W'(MAX_N - 1);
      end else begin
        n_last_next = IDX_W'(size_in_use - 1'b1);
      end
    end else if (issue) begin
      if (col_end) begin
        cj_next = '0;
        ci_next = ci + 1'b1;
      end else begin
        cj_next = cj + 1'b1;
      end
    end
    if (adv) begin
      tag1_next.valid     = issue;
      tag1_next.row       = ci;
      tag1_next.first_col = (cj == '0);
      tag1_next.last_col  = col_end;
      tag1_next.last_row  = row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      size_in_use <= SIZE_W'(SIZE_RST);
      tag1        <= '0;
    end else begin
      state <= state_next;
      tag1  <= tag1_next;
      if (cfg_we) begin
        size_in_use <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ci     <= ci_next;
    cj     <= cj_next;
    n_last <= n_last_next;
  end

  // Output register: a held word frees up as the new one loads.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= mac_fire || (res_valid && res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (mac_fire) begin
      res <= mac_word;
    end
  end

endmodule

// ----- sv/mvm_checker.sv -----
module mvm_checker
  import mvm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_stall,
  input cmd_word_t cmd,
  input logic      res_valid,
  input logic      res_stall,
  input res_word_t res
);

  // A held result word keeps its contents.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // An accepted compute closes the command channel.
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && cmd.kind == KIND_COMPUTE |=> cmd_stall)
    else $error("command taken during a compute");

  // A result that is not the final row means the compute is still running.
  a_rows_pending: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> cmd_stall)
    else $error("command channel open with rows still to come");

  // After reset nothing is pending and commands are taken.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !res_valid && !cmd_stall)
    else $error("state not cleared by reset");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (.*);

// ----- test/matrix_vector_multiply_tb.sv -----
module matrix_vector_multiply_tb;
  import mvm_pkg::*;

  // Clock, run length and pacing.
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 250;
  // Cycles to let pass after the last expected word before a register write
  // or the end of the run, so that nothing still in flight is missed.
  localparam int DRAIN_CYCLES = 8;
  // Length of the one long receiver hold-off that backs up the pipeline.
  localparam int HOLD_CYCLES  = 80;
  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_STEPS    = 26;

  // A kind code that the block has to ignore.
  localparam logic [KIND_W-1:0] KIND_NOISE = 2'd3;

  // Element values of interest, in Q8.8.
  localparam logic [VALUE_W-1:0] VAL_MAX     = 16'h7fff;
  localparam logic [VALUE_W-1:0] VAL_MIN     = 16'h8000;
  localparam logic [VALUE_W-1:0] VAL_ONE     = 16'h0100;
  localparam logic [VALUE_W-1:0] VAL_ZERO    = 16'h0000;
  localparam logic [VALUE_W-1:0] VAL_NEG_LSB = 16'hffff;

  // Saturation bounds of the row sum.
  localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  // One row of the directed part: either a register write or a command word.
  // Where typed is set, the single result word of a size-one compute is
  // written into the row instead of taken from the predictor.
  typedef struct {
    bit                      is_cfg;
    logic [SIZE_W-1:0]       size;
    cmd_word_t               word;
    bit                      typed;
    logic signed [SUM_W-1:0] sum;
  } step_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  cmd_word_t         cmd = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  res_word_t         res;

  // Our own copy of the block's state: both stores, which entries have
  // been written, and the raw size register.
  logic signed [ELEM_W-1:0] mat_elems [MAX_N*MAX_N];
  logic signed [ELEM_W-1:0] vec_elems [MAX_N];
  bit                       mat_written [MAX_N*MAX_N];
  bit                       vec_written [MAX_N];
  logic [SIZE_W-1:0]        size_reg = SIZE_W'(SIZE_RST);

  // Row results still owed by the block, oldest first.
  res_word_t   pending_rows [$];
  step_t       directed_steps [DIR_STEPS];

  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  // When quiet is set, neither side inserts gaps for the current phase.
  bit          quiet = 1'b0;
  // Set by the stimulus, taken and cleared by the receiver.
  bit          hold_request = 1'b0;

  matrix_vector_multiply DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // A register value of 0 acts as 1 and anything above MAX_N acts as MAX_N.
  function automatic int rows_in_use(input logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_N) return MAX_N;
    return int'(s);
  endfunction

  function automatic cmd_word_t make_word(input logic [KIND_W-1:0] k, input int r,
                                          input int c, input logic [VALUE_W-1:0] v);
    cmd_word_t w;
    w.kind      = kind_t'(k);
    w.row_index = ROWF_W'(r);
    w.col_index = COLF_W'(c);
    w.value     = v;
    return w;
  endfunction

  // Element values lean toward the two extremes now and then.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic step_t cfg_step(input logic [SIZE_W-1:0] s);
    step_t st;
    st        = '{default: '0};
    st.is_cfg = 1'b1;
    st.size   = s;
    return st;
  endfunction

  function automatic step_t item_step(input logic [KIND_W-1:0] k, input int r, input int c,
                                      input logic [VALUE_W-1:0] v, input bit typed,
                                      input logic signed [SUM_W-1:0] sum);
    step_t st;
    st       = '{default: '0};
    st.word  = make_word(k, r, c, v);
    st.typed = typed;
    st.sum   = sum;
    return st;
  endfunction

  // Offers one word after a random gap, holds it until it is accepted, then
  // applies it to the local state. A compute queues one word per row, either
  // from the directed row or from the sums worked out here.
  task automatic send_word(input cmd_word_t w, input bit typed,
                           input logic signed [SUM_W-1:0] typed_sum);
    int unsigned gap;
    int          n;
    longint      acc;
    res_word_t   row_word;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= w;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    // The word was taken at this edge.
    case (w.kind)
      KIND_LOAD_MAT: begin
        mat_elems[w.row_index * MAX_N + w.col_index]   = w.value;
        mat_written[w.row_index * MAX_N + w.col_index] = 1'b1;
        items_sent++;
      end
      KIND_LOAD_VEC: begin
        vec_elems[w.col_index]   = w.value;
        vec_written[w.col_index] = 1'b1;
        items_sent++;
      end
      KIND_COMPUTE: begin
        n = rows_in_use(size_reg);
        for (int i = 0; i < n; i++) begin
          acc = 0;
          for (int j = 0; j < n; j++) begin
            acc = acc + longint'(mat_elems[i * MAX_N + j]) * longint'(vec_elems[j]);
            if (acc > SUM_HI) acc = SUM_HI;
            if (acc < SUM_LO) acc = SUM_LO;
          end
          row_word.out_row = OUT_ROW_W'(i);
          row_word.dot_sum = typed ? typed_sum : SUM_W'(acc);
          row_word.last    = (i == n - 1);
          pending_rows.push_back(row_word);
        end
        items_sent++;
      end
      default: begin
        // Unknown kinds leave the block untouched.
      end
    endcase
  endtask

  // Stops offering words, waits for every owed row, then lets the pipeline settle.
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The size register is only written while the block has nothing to do.
  task automatic write_size(input logic [SIZE_W-1:0] s);
    wait_idle();
    cfg_wdata <= s;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    size_reg = s;
  endtask

  // One random phase: set a size, load every element of the block in use
  // that has not been written yet, mix in random loads and ignored words,
  // then compute, sometimes twice. With pressure set, the receiver is asked
  // for its long hold-off right before the compute and loads keep coming
  // behind it, so the block backs up and stalls its command side.
  task automatic run_phase(input logic [SIZE_W-1:0] s, input bit pressure);
    int n;
    int r;
    int c;
    write_size(s);
    quiet = ($urandom_range(0, 4) == 0);
    n = rows_in_use(s);
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++)
        if (!mat_written[r * MAX_N + c])
          send_word(make_word(KIND_LOAD_MAT, r, c, pick_value()), 1'b0, '0);
    for (c = 0; c < n; c++)
      if (!vec_written[c])
        send_word(make_word(KIND_LOAD_VEC, 0, c, pick_value()), 1'b0, '0);
    repeat ($urandom_range(1, 2 * n + 2)) begin
      case ($urandom_range(0, 7))
        0: send_word(make_word(KIND_NOISE, $urandom_range(0, MAX_N - 1),
                               $urandom_range(0, MAX_N - 1), VALUE_W'($urandom)), 1'b0, '0);
        1, 2: send_word(make_word(KIND_LOAD_VEC, $urandom_range(0, MAX_N - 1),
                                  $urandom_range(0, MAX_N - 1), pick_value()), 1'b0, '0);
        // Most matrix loads land inside the block in use.
        3: send_word(make_word(KIND_LOAD_MAT, $urandom_range(0, MAX_N - 1),
                               $urandom_range(0, MAX_N - 1), pick_value()), 1'b0, '0);
        default: send_word(make_word(KIND_LOAD_MAT, $urandom_range(0, n - 1),
                                     $urandom_range(0, n - 1), pick_value()), 1'b0, '0);
      endcase
    end
    if (pressure) hold_request = 1'b1;
    send_word(make_word(KIND_COMPUTE, $urandom_range(0, MAX_N - 1),
                        $urandom_range(0, MAX_N - 1), VALUE_W'($urandom)), 1'b0, '0);
    if (pressure)
      repeat (6)
        send_word(make_word(KIND_LOAD_MAT, $urandom_range(0, n - 1),
                            $urandom_range(0, n - 1), pick_value()), 1'b0, '0);
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(0, 3))
        send_word(make_word(KIND_LOAD_VEC, 0, $urandom_range(0, n - 1), pick_value()),
                  1'b0, '0);
      send_word(make_word(KIND_COMPUTE, 0, 0, VAL_ZERO), 1'b0, '0);
    end
  endtask

  // Stimulus: reset, the directed table, then random phases. The full
  // 16 by 16 block is loaded once so that the largest sizes, and register
  // values above MAX_N, can be used from then on.
  initial begin : stimulus
    int          phase;
    bit          full_loaded;
    logic [SIZE_W-1:0] s;

    // Size one first, so each compute gives a single word that can be
    // worked out by hand: products of the extremes, zero, one times one.
    directed_steps[0]  = cfg_step(1);
    directed_steps[1]  = item_step(KIND_LOAD_MAT, 0, 0, VAL_MAX, 1'b0, '0);
    directed_steps[2]  = item_step(KIND_LOAD_VEC, 0, 0, VAL_MAX, 1'b0, '0);
    directed_steps[3]  = item_step(KIND_COMPUTE, 0, 0, VAL_ZERO, 1'b1, 40'sd1073676289);
    directed_steps[4]  = item_step(KIND_LOAD_VEC, 0, 0, VAL_MIN, 1'b0, '0);
    directed_steps[5]  = item_step(KIND_COMPUTE, 0, 0, VAL_ZERO, 1'b1, -40'sd1073709056);
    directed_steps[6]  = item_step(KIND_LOAD_MAT, 0, 0, VAL_MIN, 1'b0, '0);
    directed_steps[7]  = item_step(KIND_COMPUTE, 0, 0, VAL_ZERO, 1'b1, 40'sd1073741824);
    directed_steps[8]  = item_step(KIND_LOAD_MAT, 0, 0, VAL_ZERO, 1'b0, '0);
    directed_steps[9]  = item_step(KIND_COMPUTE, 0, 0, VAL_ZERO, 1'b1, 40'sd0);
    directed_steps[10] = item_step(KIND_LOAD_MAT, 0, 0, VAL_ONE, 1'b0, '0);
    directed_steps[11] = item_step(KIND_LOAD_VEC, 0, 0, VAL_ONE, 1'b0, '0);
    directed_steps[12] = item_step(KIND_COMPUTE, 0, 0, VAL_ZERO, 1'b1, 40'sd65536);
    // An unknown kind aimed at element zero must not change it.
    directed_steps[13] = item_step(KIND_NOISE, 0, 0, VAL_NEG_LSB, 1'b0, '0);
    directed_steps[14] = item_step(KIND_COMPUTE, 0, 0, VAL_ZERO, 1'b1, 40'sd65536);
    // A size of zero behaves as size one.
    directed_steps[15] = cfg_step(0);
    directed_steps[16] = item_step(KIND_COMPUTE, 0, 0, VAL_ZERO, 1'b1, 40'sd65536);
    // Highest indices, then a two by two block computed twice back to back.
    directed_steps[17] = item_step(KIND_LOAD_MAT, 15, 15, VAL_NEG_LSB, 1'b0, '0);
    directed_steps[18] = item_step(KIND_LOAD_VEC, 15, 15, VAL_MIN, 1'b0, '0);
    directed_steps[19] = item_step(KIND_LOAD_MAT, 0, 1, VAL_MAX, 1'b0, '0);
    directed_steps[20] = item_step(KIND_LOAD_MAT, 1, 0, VAL_MIN, 1'b0, '0);
    directed_steps[21] = item_step(KIND_LOAD_MAT, 1, 1, VAL_NEG_LSB, 1'b0, '0);
    directed_steps[22] = item_step(KIND_LOAD_VEC, 0, 1, VAL_MAX, 1'b0, '0);
    directed_steps[23] = cfg_step(2);
    directed_steps[24] = item_step(KIND_COMPUTE, 0, 0, VAL_ZERO, 1'b0, '0);
    directed_steps[25] = item_step(KIND_COMPUTE, 15, 15, VAL_NEG_LSB, 1'b0, '0);

    phase       = 0;
    full_loaded = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_STEPS; i++) begin
      if (directed_steps[i].is_cfg) begin
        write_size(directed_steps[i].size);
      end else begin
        send_word(directed_steps[i].word, directed_steps[i].typed, directed_steps[i].sum);
      end
    end

    while (items_sent < DIR_STEPS + RANDOM_ITEMS) begin
      if (!full_loaded && items_sent >= 60) begin
        s           = SIZE_W'(MAX_N);
        full_loaded = 1'b1;
      end else if (full_loaded && $urandom_range(0, 2) == 0) begin
        s = SIZE_W'($urandom_range(MAX_N, 31));
      end else begin
        s = SIZE_W'($urandom_range(0, 6));
      end
      run_phase(s, phase == 2);
      phase++;
    end
    // The largest register value, which acts as MAX_N.
    run_phase(SIZE_W'(31), 1'b0);

    wait_idle();
    if (mismatches == 0) begin
      $display("matrix_vector_multiply regression: pass");
    end else begin
      $display("matrix_vector_multiply regression: fail");
    end
    $finish;
  end

  // Receiver: stalls for a random number of cycles before each word, or for
  // the long hold-off when the stimulus asks for one.
  initial begin : receiver
    int unsigned wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        wait_cycles  = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (quiet) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 3);
      end
      if (wait_cycles > 0) begin
        res_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid && !hold_request);
    end
  end

  // Every accepted result word is matched against the oldest owed row.
  always @(posedge clk) begin
    res_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: row %0d sum %0d last %0b",
                   res.out_row, res.dot_sum, res.last);
      end else begin
        want = pending_rows.pop_front();
        if (res.out_row !== want.out_row || res.dot_sum !== want.dot_sum ||
            res.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected row %0d sum %0d last %0b,",
                     want.out_row, want.dot_sum, want.last,
                     " got row %0d sum %0d last %0b",
                     res.out_row, res.dot_sum, res.last);
        end
      end
    end
  end

  // Hang detection: any accepted word or register write restarts the count.
  always @(posedge clk) begin
    if (rst || cfg_we || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("matrix_vector_multiply regression: fail");
      $finish;
    end
  end

endmodule

// ----- files.f -----
sv/mvm_pkg.sv
sv/mvm_ram.sv
sv/mvm_mac.sv
sv/matrix_vector_multiply.sv
sv/mvm_checker.sv
test/matrix_vector_multiply_tb.sv
